@@ rtl/hcfm_pkg.sv @@
// Shared types and constants of the hysteresis crossing frequency meter.
`default_nettype none
package hcfm_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [1:0] REG_THRESHOLD   = 2'd1;
  localparam logic [1:0] REG_HYSTERESIS  = 2'd2;

  localparam logic [31:0] RATE_RESET = 32'd48000;
  localparam logic [9:0]  MILLI      = 10'd1000;
  localparam logic [63:0] ONE_Q16    = 64'h0000_0000_0001_0000;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               end_of_block;
  } hcfm_in_t;

  typedef struct packed {
    logic        sample_rejected;
    logic        report_valid;
    logic [63:0] average_period_q16;
    logic [31:0] frequency_millihz;
    logic [31:0] periods_counted;
  } hcfm_out_t;

  // Item as it leaves the front end: the sample plus its level classification.
  typedef struct packed {
    logic signed [15:0] sample;
    logic               end_of_block;
    logic               at_or_below_lower;
    logic               at_or_above_thr;
    logic               at_or_above_upper;
  } hcfm_item_t;

  typedef struct packed {
    logic [31:0]        sample_rate_hz;
    logic signed [15:0] threshold_level;
    logic [15:0]        hysteresis_band;
  } hcfm_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_INTERP,
    ST_CONF,
    ST_CHECK,
    ST_REPORT,
    ST_MEAN,
    ST_ROUND,
    ST_FREQ,
    ST_OUT
  } hcfm_state_t;

endpackage
`default_nettype wire

@@ rtl/hcfm_div.sv @@
// Shared bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module hcfm_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      quotient,
  output logic [63:0]      remainder
);

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] div_r, div_nxt;
  logic        done_r, done_nxt;
  logic [64:0] shifted;
  logic [64:0] diff;

  always_comb begin
    shifted  = {rem_r, quo_r[63]};
    diff     = shifted - {1'b0, div_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
      rem_nxt  = 64'd0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[64]) begin
        rem_nxt = diff[63:0];
      end else begin
        rem_nxt = shifted[63:0];
      end
      quo_nxt = {quo_r[62:0], ~diff[64]};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 6'd0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

@@ rtl/hcfm_front.sv @@
// Front end: takes input transfers, classifies each sample against the levels and queues it.
`default_nettype none
module hcfm_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hcfm_pkg::hcfm_cfg_t cfg,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire hcfm_pkg::hcfm_in_t in_data,
  output logic                    item_valid,
  output hcfm_pkg::hcfm_item_t    item,
  input  wire logic               item_pop
);

  hcfm_pkg::hcfm_item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;
  logic signed [17:0] lower_raw, upper_raw;
  logic signed [17:0] lower, upper;
  logic signed [17:0] x_ext, thr_ext;
  hcfm_pkg::hcfm_item_t cls;

  always_comb begin
    x_ext     = 18'(in_data.sample);
    thr_ext   = 18'(cfg.threshold_level);
    lower_raw = thr_ext - $signed({2'b00, cfg.hysteresis_band});
    upper_raw = thr_ext + $signed({2'b00, cfg.hysteresis_band});
    lower     = (lower_raw < -18'sd32768) ? -18'sd32768 : lower_raw;
    upper     = (upper_raw > 18'sd32767) ? 18'sd32767 : upper_raw;
    cls.sample            = in_data.sample;
    cls.end_of_block      = in_data.end_of_block;
    cls.at_or_below_lower = (x_ext <= lower);
    cls.at_or_above_thr   = (x_ext >= thr_ext);
    cls.at_or_above_upper = (x_ext >= upper);
  end

  assign in_stall   = (count_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign item_valid = (count_r != 2'd0);
  assign pop        = item_pop && item_valid;
  assign item       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

@@ rtl/hcfm_back.sv @@
// Back end: crossing tracking, period accumulation, report computation and result register.
`default_nettype none
module hcfm_back #(
  parameter int unsigned INDEX_BITS = 48
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire hcfm_pkg::hcfm_cfg_t  cfg,
  input  wire logic                 clear,
  input  wire logic                 item_valid,
  input  wire hcfm_pkg::hcfm_item_t item,
  output logic                      item_pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output hcfm_pkg::hcfm_out_t       out_data
);

  hcfm_pkg::hcfm_state_t state_r, state_nxt;

  // Architectural state.
  logic signed [15:0]    prev_r;
  logic [INDEX_BITS-1:0] idx_r;
  logic [63:0]           pend_pos_r;
  logic [63:0]           last_pos_r;
  logic [63:0]           sum_r;
  logic [31:0]           total_r;
  logic                  started_r, armed_r, pending_r, have_last_r;

  // Per-item working registers.
  hcfm_pkg::hcfm_item_t  cur_r;
  logic [63:0]           base_r;
  logic [63:0]           npos_r;
  logic [63:0]           period_r;
  logic                  n_pend_pre_r;
  logic                  acc_r, n_armed_r, n_pend_r;
  logic                  rej_r, valid_r;
  logic [63:0]           q_r;
  logic [41:0]           num_r;
  logic [31:0]           freq_r;
  logic                  out_valid_r;
  hcfm_pkg::hcfm_out_t   out_r;

  logic        div_start;
  logic [63:0] div_dividend, div_divisor;
  logic        div_done;
  logic [63:0] div_quo, div_rem;

  logic signed [16:0]    off_full, span_full;
  logic [15:0]           off, span;
  logic [INDEX_BITS-1:0] idx_dec;
  logic [63:0]           base_c;
  logic                  base_rej, rise_cross;
  logic                  c_acc, c_armed, c_pend;
  logic [64:0]           sum65;
  logic                  chk_rej;
  logic                  mean_up;
  logic                  out_free;

  hcfm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    off_full   = 17'(cfg.threshold_level) - 17'(prev_r);
    span_full  = 17'(cur_r.sample) - 17'(prev_r);
    off        = off_full[15:0];
    span       = span_full[15:0];
    idx_dec    = idx_r - {{(INDEX_BITS-1){1'b0}}, 1'b1};
    base_c     = 64'(idx_dec) << 16;
    base_rej   = (cfg.sample_rate_hz == 32'd0) || (idx_r == {INDEX_BITS{1'b1}});
    rise_cross = armed_r && !pending_r && (prev_r < cfg.threshold_level) &&
                 cur_r.at_or_above_thr;
    // Arm / confirm decision once the candidate crossing is known.
    c_acc   = 1'b0;
    c_armed = armed_r;
    c_pend  = n_pend_pre_r;
    if (armed_r) begin
      if (n_pend_pre_r) begin
        if (cur_r.at_or_above_upper) begin
          c_acc   = 1'b1;
          c_armed = 1'b0;
          c_pend  = 1'b0;
        end else if (!cur_r.at_or_above_thr) begin
          c_pend = 1'b0;
        end
      end
    end else if (cur_r.at_or_below_lower) begin
      c_armed = 1'b1;
      c_pend  = 1'b0;
    end
    sum65   = {1'b0, sum_r} + {1'b0, period_r};
    chk_rej = acc_r && have_last_r &&
              ((period_r == 64'd0) || sum65[64] || (total_r == 32'hFFFF_FFFF));
    mean_up = (div_rem[31:0] >= (total_r - {1'b0, total_r[31:1]}));
    out_free = !out_valid_r || !out_stall;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hcfm_pkg::ST_IDLE: begin
        if (item_valid) state_nxt = hcfm_pkg::ST_EVAL;
      end
      hcfm_pkg::ST_EVAL: begin
        if (base_rej) begin
          state_nxt = hcfm_pkg::ST_OUT;
        end else if (!started_r) begin
          state_nxt = hcfm_pkg::ST_REPORT;
        end else if (rise_cross && (off < span)) begin
          state_nxt = hcfm_pkg::ST_INTERP;
        end else begin
          state_nxt = hcfm_pkg::ST_CONF;
        end
      end
      hcfm_pkg::ST_INTERP: begin
        if (div_done) state_nxt = hcfm_pkg::ST_CONF;
      end
      hcfm_pkg::ST_CONF:  state_nxt = hcfm_pkg::ST_CHECK;
      hcfm_pkg::ST_CHECK: state_nxt = hcfm_pkg::ST_REPORT;
      hcfm_pkg::ST_REPORT: begin
        if (cur_r.end_of_block && !rej_r && (total_r != 32'd0)) begin
          state_nxt = hcfm_pkg::ST_MEAN;
        end else begin
          state_nxt = hcfm_pkg::ST_OUT;
        end
      end
      hcfm_pkg::ST_MEAN: begin
        if (div_done) state_nxt = hcfm_pkg::ST_ROUND;
      end
      hcfm_pkg::ST_ROUND: begin
        state_nxt = (q_r == 64'd0) ? hcfm_pkg::ST_OUT : hcfm_pkg::ST_FREQ;
      end
      hcfm_pkg::ST_FREQ: begin
        if (div_done) state_nxt = hcfm_pkg::ST_OUT;
      end
      hcfm_pkg::ST_OUT: begin
        if (out_free) state_nxt = hcfm_pkg::ST_IDLE;
      end
      default: state_nxt = hcfm_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    item_pop     = 1'b0;
    div_start    = 1'b0;
    div_dividend = {32'd0, off, 16'd0};
    div_divisor  = {48'd0, span};
    case (state_r)
      hcfm_pkg::ST_IDLE: item_pop = item_valid;
      hcfm_pkg::ST_EVAL: begin
        div_start = !base_rej && started_r && rise_cross && (off < span);
      end
      hcfm_pkg::ST_REPORT: begin
        div_start    = cur_r.end_of_block && !rej_r && (total_r != 32'd0);
        div_dividend = sum_r;
        div_divisor  = {32'd0, total_r};
      end
      hcfm_pkg::ST_ROUND: begin
        div_start    = (q_r != 64'd0);
        div_dividend = {6'd0, num_r, 16'd0} + {1'b0, q_r[63:1]};
        div_divisor  = q_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hcfm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      idx_r       <= '0;
      pend_pos_r  <= '0;
      last_pos_r  <= '0;
      sum_r       <= '0;
      total_r     <= '0;
      started_r   <= 1'b0;
      armed_r     <= 1'b0;
      pending_r   <= 1'b0;
      have_last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == hcfm_pkg::ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (clear) begin
        prev_r      <= '0;
        idx_r       <= '0;
        pend_pos_r  <= '0;
        last_pos_r  <= '0;
        sum_r       <= '0;
        total_r     <= '0;
        started_r   <= 1'b0;
        armed_r     <= 1'b0;
        pending_r   <= 1'b0;
        have_last_r <= 1'b0;
      end else begin
        case (state_r)
          hcfm_pkg::ST_EVAL: begin
            if (!base_rej && !started_r) begin
              prev_r    <= cur_r.sample;
              armed_r   <= cur_r.at_or_below_lower;
              started_r <= 1'b1;
              idx_r     <= idx_r + {{(INDEX_BITS-1){1'b0}}, 1'b1};
            end
          end
          hcfm_pkg::ST_CHECK: begin
            if (!chk_rej) begin
              if (acc_r) begin
                if (have_last_r) begin
                  sum_r   <= sum65[63:0];
                  total_r <= total_r + 32'd1;
                end
                last_pos_r  <= npos_r;
                have_last_r <= 1'b1;
              end
              armed_r    <= n_armed_r;
              pending_r  <= n_pend_r;
              pend_pos_r <= npos_r;
              prev_r     <= cur_r.sample;
              idx_r      <= idx_r + {{(INDEX_BITS-1){1'b0}}, 1'b1};
            end
          end
          default: begin
            idx_r <= idx_r;
          end
        endcase
      end
    end

    // Working registers need no reset.
    case (state_r)
      hcfm_pkg::ST_IDLE: begin
        if (item_valid) cur_r <= item;
      end
      hcfm_pkg::ST_EVAL: begin
        rej_r        <= base_rej;
        valid_r      <= 1'b0;
        base_r       <= base_c;
        n_pend_pre_r <= pending_r || rise_cross;
        if (rise_cross) begin
          npos_r <= base_c + hcfm_pkg::ONE_Q16;
        end else begin
          npos_r <= pend_pos_r;
        end
      end
      hcfm_pkg::ST_INTERP: begin
        if (div_done) npos_r <= base_r + {48'd0, div_quo[15:0]};
      end
      hcfm_pkg::ST_CONF: begin
        acc_r     <= c_acc;
        n_armed_r <= c_armed;
        n_pend_r  <= c_pend;
        period_r  <= npos_r - last_pos_r;
      end
      hcfm_pkg::ST_CHECK: begin
        rej_r <= chk_rej;
      end
      hcfm_pkg::ST_REPORT: begin
        num_r <= 42'(cfg.sample_rate_hz) * 42'(hcfm_pkg::MILLI);
      end
      hcfm_pkg::ST_MEAN: begin
        if (div_done) q_r <= div_quo + {63'd0, mean_up};
      end
      hcfm_pkg::ST_FREQ: begin
        if (div_done) begin
          freq_r  <= (div_quo[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_quo[31:0];
          valid_r <= 1'b1;
        end
      end
      hcfm_pkg::ST_OUT: begin
        if (out_free) begin
          out_r.sample_rejected    <= rej_r;
          out_r.report_valid       <= valid_r;
          out_r.average_period_q16 <= valid_r ? q_r : 64'd0;
          out_r.frequency_millihz  <= valid_r ? freq_r : 32'd0;
          out_r.periods_counted    <= total_r;
        end
      end
      default: begin
        cur_r <= cur_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

@@ rtl/hysteresis_crossing_frequency_meter_core.sv @@
// Top level of the hysteresis crossing frequency meter: register port and the two halves.
`default_nettype none
// The meter takes signed 16-bit samples and gives one result transfer per sample. A
// rising crossing is armed at or below threshold minus hysteresis and confirmed at or
// above threshold plus hysteresis; its position is interpolated to 1/65536 of a sample
// and the periods between crossings are summed. A sample with end_of_block set also
// reports the rounded mean period (Q48.16) and the frequency in millihertz. The front
// end classifies samples and holds up to two in a queue, so input transfers continue
// while the back end works and while a finished result waits for the sink. The back
// end handles one sample at a time. Interpolating a crossing and computing a report
// use the shared bit-serial divider, which makes one quotient bit per cycle over 64
// bits. Writing any register clears all measurement state; writes are expected only
// while the block is idle. There is no clearing pass after reset.
module hysteresis_crossing_frequency_meter_core #(
  parameter int unsigned INDEX_BITS = 48
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire hcfm_pkg::hcfm_in_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output hcfm_pkg::hcfm_out_t              out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [hcfm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  hcfm_pkg::hcfm_cfg_t  cfg_r;
  logic                 cfg_write;
  logic                 cfg_hit;
  logic                 item_valid;
  logic                 item_pop;
  hcfm_pkg::hcfm_item_t item;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // A write to any of the three registers also clears the measurement state.
  always_comb begin
    case (paddr[3:2])
      hcfm_pkg::REG_SAMPLE_RATE: begin
        cfg_hit = 1'b1;
        prdata  = cfg_r.sample_rate_hz;
      end
      hcfm_pkg::REG_THRESHOLD: begin
        cfg_hit = 1'b1;
        prdata  = {16'd0, cfg_r.threshold_level};
      end
      hcfm_pkg::REG_HYSTERESIS: begin
        cfg_hit = 1'b1;
        prdata  = {16'd0, cfg_r.hysteresis_band};
      end
      default: begin
        cfg_hit = 1'b0;
        prdata  = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_rate_hz  <= hcfm_pkg::RATE_RESET;
      cfg_r.threshold_level <= 16'sd0;
      cfg_r.hysteresis_band <= 16'd0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        hcfm_pkg::REG_SAMPLE_RATE: cfg_r.sample_rate_hz  <= pwdata;
        hcfm_pkg::REG_THRESHOLD:   cfg_r.threshold_level <= pwdata[15:0];
        hcfm_pkg::REG_HYSTERESIS:  cfg_r.hysteresis_band <= pwdata[15:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  hcfm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  hcfm_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .clear      (cfg_write && cfg_hit),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire
